>>> src/mexp_pkg.sv
// Shared constants, types and state encodings for the modular exponentiation core.
package mexp_pkg;

    localparam int DEFAULT_EXP_WIDTH = 31;
    localparam int BASE_W            = 31;
    localparam int EXP_IN_W          = 31;
    localparam int RESULT_W          = 30;

    localparam logic [RESULT_W-1:0] PRIME_MOD  = 30'd1000000007;
    localparam logic [30:0]         BARRETT_MU = 31'd1152921496;

    typedef struct packed {
        logic              start;
        logic [BASE_W-1:0] a;
        logic [BASE_W-1:0] b;
    } mm_req_t;

    typedef struct packed {
        logic                done;
        logic [RESULT_W-1:0] product;
    } mm_rsp_t;

    typedef enum logic [2:0] {
        MM_IDLE,
        MM_EST,
        MM_QMUL,
        MM_SUB,
        MM_CORR
    } mm_state_t;

    typedef enum logic [2:0] {
        ME_IDLE,
        ME_REDUCE,
        ME_SQUARE,
        ME_MULT,
        ME_OUT
    } me_state_t;

endpackage

>>> src/mexp_if.sv
// Valid/ready channel interfaces for the operand and result words.
interface mexp_in_if;
    logic                           valid;
    logic                           ready;
    logic [mexp_pkg::BASE_W-1:0]    base_value;
    logic [mexp_pkg::EXP_IN_W-1:0]  exponent;

    modport source (output valid, output base_value, output exponent, input ready);
    modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

interface mexp_out_if;
    logic                           valid;
    logic                           ready;
    logic [mexp_pkg::RESULT_W-1:0]  power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

>>> src/modular_exponentiation_core.sv
// Top level of the modular exponentiation core with the square-and-multiply sequencer.
//
// The core takes one operand word (base and exponent) and returns base to the power exponent
// modulo 1000000007 as one result word. It works on one word at a time and is not ready
// while a word is in progress or its result waits to be taken. The exponent is scanned from
// bit EXP_WIDTH-1 down to bit 0; each bit costs a squaring and each set bit a further
// multiplication by the base, after one initial reduction of the base. Every modular product
// goes through a single shared 32x32 multiplier three times (product, quotient estimate,
// quotient times prime), and how long it takes depends on how many final corrections
// it needs. A word therefore takes 1 + EXP_WIDTH + set exponent bits products, which is 32
// plus one per set exponent bit at the default width of 31 bits, besides acceptance and
// delivery and any time the result waits to be taken.
module modular_exponentiation_core
#(
    parameter int EXP_WIDTH = mexp_pkg::DEFAULT_EXP_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    mexp_in_if.sink     operands,
    mexp_out_if.source  result
);

    localparam int CNT_W = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;

    mexp_pkg::me_state_t state_reg;
    mexp_pkg::me_state_t state_next;

    logic                              start_reg;
    logic                              start_next;
    logic [CNT_W-1:0]                  cnt_reg;
    logic [CNT_W-1:0]                  cnt_next;
    logic [EXP_WIDTH-1:0]              exp_reg;
    logic [EXP_WIDTH-1:0]              exp_next;
    logic [mexp_pkg::BASE_W-1:0]       base_reg;
    logic [mexp_pkg::BASE_W-1:0]       base_next;
    logic [mexp_pkg::RESULT_W-1:0]     b_reg;
    logic [mexp_pkg::RESULT_W-1:0]     b_next;
    logic [mexp_pkg::RESULT_W-1:0]     acc_reg;
    logic [mexp_pkg::RESULT_W-1:0]     acc_next;
    logic [EXP_WIDTH+mexp_pkg::EXP_IN_W-1:0] exp_ext;
    logic                              accept;

    mexp_pkg::mm_req_t mm_req;
    mexp_pkg::mm_rsp_t mm_rsp;

    mexp_modmul u_modmul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .rsp   (mm_rsp)
    );

    assign exp_ext             = {{EXP_WIDTH{1'b0}}, operands.exponent};
    assign operands.ready      = (state_reg == mexp_pkg::ME_IDLE);
    assign accept              = operands.valid && operands.ready;
    assign result.valid        = (state_reg == mexp_pkg::ME_OUT);
    assign result.power_result = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mexp_pkg::ME_IDLE;
            start_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg  <= exp_next;
        base_reg <= base_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        mm_req.start = start_reg;
        mm_req.a     = {1'b0, acc_reg};
        mm_req.b     = {1'b0, acc_reg};
        case (state_reg)
            mexp_pkg::ME_REDUCE:
            begin
                mm_req.a = base_reg;
                mm_req.b = {{(mexp_pkg::BASE_W-1){1'b0}}, 1'b1};
            end
            mexp_pkg::ME_MULT:
            begin
                mm_req.b = {1'b0, b_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        start_next = 1'b0;
        cnt_next   = cnt_reg;
        exp_next   = exp_reg;
        base_next  = base_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        case (state_reg)
            mexp_pkg::ME_IDLE:
            begin
                if (accept)
                begin
                    base_next  = operands.base_value;
                    exp_next   = exp_ext[EXP_WIDTH-1:0];
                    acc_next   = {{(mexp_pkg::RESULT_W-1){1'b0}}, 1'b1};
                    start_next = 1'b1;
                    state_next = mexp_pkg::ME_REDUCE;
                end
            end
            mexp_pkg::ME_REDUCE:
            begin
                if (mm_rsp.done)
                begin
                    b_next     = mm_rsp.product;
                    cnt_next   = CNT_W'(EXP_WIDTH - 1);
                    start_next = 1'b1;
                    state_next = mexp_pkg::ME_SQUARE;
                end
            end
            mexp_pkg::ME_SQUARE:
            begin
                if (mm_rsp.done)
                begin
                    acc_next = mm_rsp.product;
                    if (exp_reg[EXP_WIDTH-1])
                    begin
                        start_next = 1'b1;
                        state_next = mexp_pkg::ME_MULT;
                    end
                    else if (cnt_reg == '0)
                    begin
                        state_next = mexp_pkg::ME_OUT;
                    end
                    else
                    begin
                        exp_next   = exp_reg << 1;
                        cnt_next   = cnt_reg - 1'b1;
                        start_next = 1'b1;
                    end
                end
            end
            mexp_pkg::ME_MULT:
            begin
                if (mm_rsp.done)
                begin
                    acc_next = mm_rsp.product;
                    if (cnt_reg == '0)
                    begin
                        state_next = mexp_pkg::ME_OUT;
                    end
                    else
                    begin
                        exp_next   = exp_reg << 1;
                        cnt_next   = cnt_reg - 1'b1;
                        start_next = 1'b1;
                        state_next = mexp_pkg::ME_SQUARE;
                    end
                end
            end
            mexp_pkg::ME_OUT:
            begin
                if (result.ready)
                begin
                    state_next = mexp_pkg::ME_IDLE;
                end
            end
            default:
            begin
                state_next = mexp_pkg::ME_IDLE;
            end
        endcase
    end

endmodule

>>> src/mexp_modmul.sv
// Shared modular multiplier: one 32x32 multiplier reused for the product and Barrett reduction.
module mexp_modmul
(
    input  logic              clk,
    input  logic              rst_n,
    input  mexp_pkg::mm_req_t req,
    output mexp_pkg::mm_rsp_t rsp
);

    mexp_pkg::mm_state_t state_reg;
    mexp_pkg::mm_state_t state_next;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_reg;
    logic [31:0] plow_reg;
    logic [31:0] plow_next;
    logic [31:0] rem_reg;
    logic [31:0] rem_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mexp_pkg::MM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg  <= mul_a * mul_b;
        plow_reg <= plow_next;
        rem_reg  <= rem_next;
    end

    always_comb
    begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        plow_next  = plow_reg;
        rem_next   = rem_reg;
        rsp        = '0;
        case (state_reg)
            mexp_pkg::MM_IDLE:
            begin
                mul_a = {1'b0, req.a};
                mul_b = {1'b0, req.b};
                if (req.start)
                begin
                    state_next = mexp_pkg::MM_EST;
                end
            end
            mexp_pkg::MM_EST:
            begin
                // The quotient estimate uses the product shifted down by 29 bits.
                mul_a      = {1'b0, mul_reg[59:29]};
                mul_b      = {1'b0, mexp_pkg::BARRETT_MU};
                plow_next  = mul_reg[31:0];
                state_next = mexp_pkg::MM_QMUL;
            end
            mexp_pkg::MM_QMUL:
            begin
                mul_a      = {1'b0, mul_reg[61:31]};
                mul_b      = {2'b00, mexp_pkg::PRIME_MOD};
                state_next = mexp_pkg::MM_SUB;
            end
            mexp_pkg::MM_SUB:
            begin
                // The remainder is below three times the prime, so 32 bits suffice.
                rem_next   = plow_reg - mul_reg[31:0];
                state_next = mexp_pkg::MM_CORR;
            end
            mexp_pkg::MM_CORR:
            begin
                if (rem_reg >= {2'b00, mexp_pkg::PRIME_MOD})
                begin
                    rem_next = rem_reg - {2'b00, mexp_pkg::PRIME_MOD};
                end
                else
                begin
                    rsp.done    = 1'b1;
                    rsp.product = rem_reg[mexp_pkg::RESULT_W-1:0];
                    state_next  = mexp_pkg::MM_IDLE;
                end
            end
            default:
            begin
                state_next = mexp_pkg::MM_IDLE;
            end
        endcase
    end

endmodule

>>> src/mexp_checker.sv
// Port-level assertions for the modular exponentiation core and their bind statement.
module mexp_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [mexp_pkg::RESULT_W-1:0] power_result
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(power_result))
        else $error("Result word changed or dropped while stalled.");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> power_result < mexp_pkg::PRIME_MOD)
        else $error("Result word is not reduced below the prime.");

    a_busy_when_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("Core is ready for a word while a result waits.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready && !out_valid)
        else $error("Core did not go busy after accepting a word.");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (operands.valid),
    .in_ready     (operands.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .power_result (result.power_result)
);
